>>> rtl/rlpm_pkg.sv
// Shared types, codes and helpers for the IPv6 route table.
// No dependencies; used by every RTL file of the block.
package rlpm_pkg;

    localparam int NUM_ENTRIES_DEF = 20;
    localparam int NUM_NETIFS_DEF  = 16;
    localparam int SLOT_W          = 6;
    localparam int SECS_W          = 21;

    localparam logic [31:0] LIFE_INFINITE = 32'hFFFF_FFFF;
    localparam logic [31:0] LIFE_LIMIT    = 32'hFFFF_FFFF / (32'd1000 * 32'd4);
    localparam logic [7:0]  LEN_MAX       = 8'd128;

    typedef enum logic [2:0] {
        OP_ADD    = 3'd0,
        OP_REMOVE = 3'd1,
        OP_ROUTE  = 3'd2,
        OP_GW     = 3'd3,
        OP_TICK   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_REJECT    = 3'd1,
        ST_FULL      = 3'd2,
        ST_BAD_INDEX = 3'd3,
        ST_NO_ROUTE  = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_COMMIT,
        S_FIN
    } t_state;

    // Request as broadcast to every cell
    typedef struct packed {
        t_op                op;
        logic [3:0]         netif;
        logic               netif_ok;
        logic [127:0]       pfx;
        logic [7:0]         len;
        logic [127:0]       mask;    // mask of len bits
        logic [127:0]       wmask;   // mask of whole bytes of len
        logic [127:0]       gw;
        logic signed [7:0]  pref;
        logic               never;
        logic [SECS_W-1:0]  secs;
        logic [SLOT_W-1:0]  idx;
        logic [127:0]       dest;
    } t_req;

    // Running result handed from cell to cell
    typedef struct packed {
        logic               best_v;
        logic [7:0]         best_len;
        logic signed [7:0]  best_pref;
        logic [SLOT_W-1:0]  best_idx;
        logic [3:0]         best_netif;
        logic [127:0]       best_gw;
        logic               hit_v;
        logic [SLOT_W-1:0]  hit_idx;
        logic               free_v;
        logic [SLOT_W-1:0]  free_idx;
    } t_carry;

    // Write of an added or refreshed route
    typedef struct packed {
        logic               en;
        logic               fresh;
        logic [SLOT_W-1:0]  slot;
    } t_commit;

    // Mask covering the first len bits of a 128-bit address
    function automatic logic [127:0] mask_of(input logic [7:0] len);
        logic [127:0] m;
        for (int k = 0; k < 128; k++) begin
            m[127-k] = (8'(k) < len);
        end
        return m;
    endfunction

endpackage

>>> rtl/rlpm_cell.sv
// One route slot of the table and its step of the scan chain.
// Depends on rlpm_pkg.
module rlpm_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rlpm_pkg::t_req    i_req,
    input  rlpm_pkg::t_commit i_commit,
    input  logic            i_tok,
    input  rlpm_pkg::t_carry  i_carry,
    output logic            o_tok,
    output rlpm_pkg::t_carry  o_carry
);
    import rlpm_pkg::*;

    localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(CELL_IDX);

    logic              r_valid;
    logic [3:0]        r_netif;
    logic [127:0]      r_pfx;
    logic [127:0]      r_mask;
    logic [7:0]        r_len;
    logic [127:0]      r_gw;
    logic signed [7:0] r_pref;
    logic [SECS_W-1:0] r_secs;
    logic              r_never;
    logic              r_tok;
    t_carry            r_carry;
    t_carry            n_carry;

    logic add_match;
    logic look_match;
    logic better;
    logic commit_me;

    assign commit_me = i_commit.en && (i_commit.slot == MY_IDX);

    // Compare against this slot
    always_comb begin
        add_match = r_valid && (r_netif == i_req.netif) && (r_len == i_req.len)
                    && (r_gw == i_req.gw) && (((r_pfx ^ i_req.pfx) & i_req.wmask) == '0);
        look_match = r_valid && (((r_pfx ^ i_req.dest) & r_mask) == '0)
                     && ((i_req.op == OP_ROUTE)
                         || (i_req.netif_ok && (r_netif == i_req.netif)));
        better = !i_carry.best_v || (r_len > i_carry.best_len)
                 || ((r_len == i_carry.best_len) && (r_pref > i_carry.best_pref));
    end

    // Fold this slot into the running result
    always_comb begin
        n_carry = i_carry;
        case (i_req.op)
            OP_ADD: begin
                if (!i_carry.hit_v && add_match) begin
                    n_carry.hit_v   = 1'b1;
                    n_carry.hit_idx = MY_IDX;
                end
                if (!i_carry.free_v && !r_valid) begin
                    n_carry.free_v   = 1'b1;
                    n_carry.free_idx = MY_IDX;
                end
            end
            OP_ROUTE, OP_GW: begin
                if (look_match && better) begin
                    n_carry.best_v     = 1'b1;
                    n_carry.best_len   = r_len;
                    n_carry.best_pref  = r_pref;
                    n_carry.best_idx   = MY_IDX;
                    n_carry.best_netif = r_netif;
                    n_carry.best_gw    = r_gw;
                end
            end
            default: begin
            end
        endcase
    end

    // Valid bit: set on commit, cleared by remove or expiry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (commit_me) begin
                r_valid <= 1'b1;
            end else if (i_tok && (i_req.op == OP_REMOVE) && (i_req.idx == MY_IDX)) begin
                r_valid <= 1'b0;
            end else if (i_tok && (i_req.op == OP_TICK) && r_valid && !r_never
                         && (r_secs <= SECS_W'(1))) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Route fields and lifetime
    always_ff @(posedge i_clk) begin
        r_carry <= n_carry;
        if (commit_me) begin
            r_pref  <= i_req.pref;
            r_never <= i_req.never;
            r_secs  <= i_req.secs;
            if (i_commit.fresh) begin
                r_netif <= i_req.netif;
                r_pfx   <= i_req.pfx;
                r_mask  <= i_req.mask;
                r_len   <= i_req.len;
                r_gw    <= i_req.gw;
            end
        end else if (i_tok && (i_req.op == OP_TICK) && r_valid && !r_never
                     && (r_secs > SECS_W'(1))) begin
            r_secs <= r_secs - SECS_W'(1);
        end
    end

    assign o_tok   = r_tok;
    assign o_carry = r_carry;

endmodule

>>> rtl/ipv6_route_table_lpm_unit.sv
// Top level of the IPv6 route table: request decode, sequencer, cell chain.
// Depends on rlpm_pkg and rlpm_cell.
//
// Usage:
//  Request channel i_req_valid / o_req_ready carries func and its operands;
//  response channel o_rsp_valid / i_rsp_ready carries status, slot, netif and
//  gateway. Each request with func 0..4 gives one response; other codes are
//  taken and dropped.
//  One request is worked at a time. A token walks the chain of NUM_ENTRIES
//  slot cells, one cell per cycle, folding best match, first hit and first
//  free slot. After accept the request passes a start step and the scan, then
//  a write step for add, before it is loaded into the response register;
//  requests rejected up front (bad interface, bad index, lifetime too long)
//  go straight to that load. A new request is taken only once the last one
//  has been loaded into the response register.
//  The response sits in an output register; a new request is taken while it
//  waits, but the next response holds until the receiver takes the old one.
//  Reset (synchronous, active low) empties the table at once.
module ipv6_route_table_lpm_unit
    import rlpm_pkg::*;
#(
    parameter int NUM_ENTRIES = NUM_ENTRIES_DEF,
    parameter int NUM_NETIFS  = NUM_NETIFS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_req_valid,
    output logic         o_req_ready,
    input  logic [2:0]   i_func,
    input  logic [3:0]   i_netif_id,
    input  logic [63:0]  i_prefix_hi,
    input  logic [63:0]  i_prefix_lo,
    input  logic [7:0]   i_prefix_len,
    input  logic [63:0]  i_gateway_hi,
    input  logic [63:0]  i_gateway_lo,
    input  logic signed [7:0] i_preference,
    input  logic [31:0]  i_lifetime,
    input  logic [5:0]   i_entry_index,
    input  logic [63:0]  i_dest_hi,
    input  logic [63:0]  i_dest_lo,
    output logic         o_rsp_valid,
    input  logic         i_rsp_ready,
    output logic [2:0]   o_status,
    output logic [5:0]   o_slot,
    output logic [3:0]   o_out_netif,
    output logic [63:0]  o_out_gateway_hi,
    output logic [63:0]  o_out_gateway_lo
);

    t_state  r_state, n_state;
    t_req    r_req, n_req;
    t_status r_status, n_status;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [3:0]   r_netif, n_netif;
    logic [127:0] r_gw, n_gw;
    logic         r_oval, n_oval;
    logic [2:0]   r_ost, n_ost;
    logic [5:0]   r_oslot, n_oslot;
    logic [3:0]   r_onetif, n_onetif;
    logic [127:0] r_ogw, n_ogw;
    t_commit      commit;

    logic   tok   [0:NUM_ENTRIES];
    t_carry carry [0:NUM_ENTRIES];

    logic       accept;
    logic [7:0] len_sat;
    logic       netif_ok;
    logic       idx_ok;
    logic       life_bad;
    t_op        in_op;

    assign accept   = i_req_valid && o_req_ready;
    assign in_op    = t_op'(i_func);
    assign len_sat  = (i_prefix_len > LEN_MAX) ? LEN_MAX : i_prefix_len;
    assign netif_ok = ({1'b0, i_netif_id} < 5'(NUM_NETIFS));
    assign idx_ok   = ({1'b0, i_entry_index} < 7'(NUM_ENTRIES));
    assign life_bad = (i_lifetime > LIFE_LIMIT) && (i_lifetime != LIFE_INFINITE);

    // Cell chain
    assign tok[0]   = (r_state == S_START);
    assign carry[0] = '0;

    for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
        rlpm_cell #(.CELL_IDX(g)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_req    (r_req),
            .i_commit (commit),
            .i_tok    (tok[g]),
            .i_carry  (carry[g]),
            .o_tok    (tok[g+1]),
            .o_carry  (carry[g+1])
        );
    end

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_req    = r_req;
        n_status = r_status;
        n_slot   = r_slot;
        n_netif  = r_netif;
        n_gw     = r_gw;
        n_oval   = r_oval && !i_rsp_ready;
        n_ost    = r_ost;
        n_oslot  = r_oslot;
        n_onetif = r_onetif;
        n_ogw    = r_ogw;
        commit   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_func <= 3'(OP_TICK))) begin
                    n_req.op       = in_op;
                    n_req.netif    = i_netif_id;
                    n_req.netif_ok = netif_ok;
                    n_req.pfx      = {i_prefix_hi, i_prefix_lo};
                    n_req.len      = len_sat;
                    n_req.mask     = mask_of(len_sat);
                    n_req.wmask    = mask_of({len_sat[7:3], 3'b000});
                    n_req.gw       = {i_gateway_hi, i_gateway_lo};
                    n_req.pref     = i_preference;
                    n_req.never    = (i_lifetime == LIFE_INFINITE);
                    n_req.secs     = (i_lifetime == LIFE_INFINITE) ? '0
                                                                   : i_lifetime[SECS_W-1:0];
                    n_req.idx      = i_entry_index;
                    n_req.dest     = {i_dest_hi, i_dest_lo};
                    n_status = ST_OK;
                    n_slot   = '0;
                    n_netif  = '0;
                    n_gw     = '0;
                    n_state  = S_START;
                    if (in_op == OP_ADD && !netif_ok) begin
                        n_status = ST_BAD_INDEX;
                        n_state  = S_FIN;
                    end else if (in_op == OP_ADD && life_bad) begin
                        n_status = ST_REJECT;
                        n_state  = S_FIN;
                    end else if (in_op == OP_REMOVE && !idx_ok) begin
                        n_status = ST_BAD_INDEX;
                        n_state  = S_FIN;
                    end
                end
            end
            S_START: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                if (tok[NUM_ENTRIES]) begin
                    n_state = S_FIN;
                    case (r_req.op)
                        OP_ADD: begin
                            n_state = S_COMMIT;
                        end
                        OP_REMOVE: begin
                            n_slot = r_req.idx;
                        end
                        OP_ROUTE, OP_GW: begin
                            if (carry[NUM_ENTRIES].best_v) begin
                                n_slot  = carry[NUM_ENTRIES].best_idx;
                                n_netif = carry[NUM_ENTRIES].best_netif;
                                n_gw    = carry[NUM_ENTRIES].best_gw;
                            end else begin
                                n_status = ST_NO_ROUTE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_COMMIT: begin
                // Final carry of the last cell holds while the request and table are unchanged
                n_state = S_FIN;
                if (carry[NUM_ENTRIES].hit_v) begin
                    commit.en    = 1'b1;
                    commit.fresh = 1'b0;
                    commit.slot  = carry[NUM_ENTRIES].hit_idx;
                end else if (carry[NUM_ENTRIES].free_v) begin
                    commit.en    = 1'b1;
                    commit.fresh = 1'b1;
                    commit.slot  = carry[NUM_ENTRIES].free_idx;
                end else begin
                    n_status = ST_FULL;
                end
                n_slot = commit.slot;
            end
            S_FIN: begin
                if (!r_oval || i_rsp_ready) begin
                    n_oval   = 1'b1;
                    n_ost    = r_status;
                    n_oslot  = r_slot;
                    n_onetif = r_netif;
                    n_ogw    = r_gw;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_oval  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oval  <= n_oval;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_netif  <= n_netif;
        r_gw     <= n_gw;
        r_ost    <= n_ost;
        r_oslot  <= n_oslot;
        r_onetif <= n_onetif;
        r_ogw    <= n_ogw;
    end

    assign o_req_ready      = (r_state == S_IDLE);
    assign o_rsp_valid      = r_oval;
    assign o_status         = r_ost;
    assign o_slot           = r_oslot;
    assign o_out_netif      = r_onetif;
    assign o_out_gateway_hi = r_ogw[127:64];
    assign o_out_gateway_lo = r_ogw[63:0];

endmodule

>>> rtl/rlpm_chk.sv
// Port-level checks on the route table responses, bound to the top level.
// Depends on rlpm_pkg and ipv6_route_table_lpm_unit.
module rlpm_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_rsp_valid,
    input logic        i_rsp_ready,
    input logic [2:0]  o_status,
    input logic [5:0]  o_slot,
    input logic [3:0]  o_out_netif,
    input logic [63:0] o_out_gateway_hi,
    input logic [63:0] o_out_gateway_lo
);
    import rlpm_pkg::*;

    // Stalled response stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid)
        else $error("response dropped while stalled");

    // Reset empties the response register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_rsp_valid)
        else $error("response valid after reset");

    // Failed requests carry no slot
    a_fail_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_status != 3'(ST_OK)) |-> (o_slot == '0))
        else $error("slot set on failed request");

    // Route data only with an ok status
    a_fail_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_status != 3'(ST_OK)) |->
            (o_out_netif == '0) && (o_out_gateway_hi == '0) && (o_out_gateway_lo == '0))
        else $error("route data on failed request");

endmodule

bind ipv6_route_table_lpm_unit rlpm_chk u_rlpm_chk (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_rsp_valid      (o_rsp_valid),
    .i_rsp_ready      (i_rsp_ready),
    .o_status         (o_status),
    .o_slot           (o_slot),
    .o_out_netif      (o_out_netif),
    .o_out_gateway_hi (o_out_gateway_hi),
    .o_out_gateway_lo (o_out_gateway_lo)
);
